// ===== rtl/block_bitmap_compactor_defines.svh =====
`ifndef BLOCK_BITMAP_COMPACTOR_DEFINES_SVH
`define BLOCK_BITMAP_COMPACTOR_DEFINES_SVH

// Both expect a clock named clk and an active-low asynchronous reset arst_n in scope.

// Same-cycle implication, checked outside reset.
`define BBC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbc assertion failed");

// Next-cycle implication, checked outside reset.
`define BBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbc assertion failed");

`endif

// ===== rtl/bbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

	localparam int NUM_BLOCKS = 1024;
	localparam int WORD_W     = 32;
	localparam int ROWS       = NUM_BLOCKS / WORD_W;
	localparam int ROW_W      = $clog2(ROWS);
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int IDX_W      = 10;
	localparam int CNT_W      = 11;
	localparam int SUM_W      = CNT_W + 1;

	localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);
	localparam logic [SUM_W-1:0] BLOCKS_SUM = SUM_W'(NUM_BLOCKS);

	// request codes
	localparam logic [1:0] MODE_BIT   = 2'd0;
	localparam logic [1:0] MODE_RELOC = 2'd1;
	localparam logic [1:0] MODE_HOLE  = 2'd2;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [BIT_W-1:0]  bitpos_t;

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b0000_0000_0001,
		ST_BIT_RD  = 12'b0000_0000_0010,
		ST_BIT_WR  = 12'b0000_0000_0100,
		ST_CLR_RD  = 12'b0000_0000_1000,
		ST_CLR_WR  = 12'b0000_0001_0000,
		ST_SRCH_RD = 12'b0000_0010_0000,
		ST_SRCH_EV = 12'b0000_0100_0000,
		ST_SET_RD  = 12'b0000_1000_0000,
		ST_SET_WR  = 12'b0001_0000_0000,
		ST_HOLE_RD = 12'b0010_0000_0000,
		ST_HOLE_EV = 12'b0100_0000_0000,
		ST_DONE    = 12'b1000_0000_0000
	} state_t;

	function automatic row_t row_of(input idx_t idx);
		return idx[IDX_W-1:BIT_W];
	endfunction

	function automatic bitpos_t bit_of(input idx_t idx);
		return idx[BIT_W-1:0];
	endfunction

	// lowest set bit, zero when none
	function automatic bitpos_t first_set(input word_t v);
		bitpos_t pos;
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i])
				pos = BIT_W'(i);
		end
		return pos;
	endfunction

	// highest set bit, zero when none
	function automatic bitpos_t last_set(input word_t v);
		bitpos_t pos;
		pos = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (v[i])
				pos = BIT_W'(i);
		end
		return pos;
	endfunction

	// bits of word row that fall inside the block range lo..last
	function automatic word_t range_mask(input row_t row, input idx_t lo, input idx_t last);
		word_t lo_m;
		word_t hi_m;
		lo_m = (row == row_of(lo)) ? ({WORD_W{1'b1}} << bit_of(lo)) : {WORD_W{1'b1}};
		hi_m = (row == row_of(last)) ? ({WORD_W{1'b1}} >> (~bit_of(last))) : {WORD_W{1'b1}};
		return lo_m & hi_m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bbc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     re,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		if (re)
			rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/block_bitmap_compactor.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "block_bitmap_compactor_defines.svh"

// Block bitmap compactor. Holds a 1024-block occupancy map (1 used, 0 free) in a
// 32 x 32-bit single-port RAM and serves one request at a time. A bit write
// (mode 0) stores one bit by read-modify-write. A relocate (mode 1) clears the
// file's range, walks the start back to the beginning of the free run it sits
// in (unless the start block is still used), marks the range at that start and
// returns it; each word touched is read, then written back or evaluated. A
// hole search (mode 2) scans the words from block 0 up, each read and then
// evaluated, for the first free run with a used block on both sides. Ranges
// that run past the map give range_error and leave the map as it was; mode 3
// returns a zero word. Each row of the RAM has a valid flop cleared by reset,
// so a row never written reads as free and no clearing pass is needed after
// reset. The next request is taken as soon as the sequencer is idle, even
// while the previous result still waits in the output register.
module block_bitmap_compactor (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                mode,
	input  wire logic [bbc_pkg::IDX_W-1:0] block_index,
	input  wire logic [bbc_pkg::CNT_W-1:0] block_count,
	input  wire logic                      bit_value,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic      [bbc_pkg::IDX_W-1:0] new_start,
	output logic                           hole_found,
	output logic      [bbc_pkg::IDX_W-1:0] hole_start,
	output logic      [bbc_pkg::IDX_W-1:0] hole_length,
	output logic                           range_error
);

	import bbc_pkg::*;

	// sequencer state
	state_t          state_q;
	row_t            row_q;
	logic [ROWS-1:0] row_valid_q;
	logic            rd_valid_q;
	logic            in_hole_q;
	logic            prev_msb_q;

	// request being served
	idx_t             idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             bit_val_q;
	idx_t             lo_q;
	idx_t             last_q;
	idx_t             hole_p_q;

	// result under construction
	idx_t res_new_start_q;
	logic res_hole_found_q;
	idx_t res_hole_start_q;
	idx_t res_hole_length_q;
	logic res_range_error_q;

	// output register
	logic out_valid_q;
	idx_t new_start_q;
	logic hole_found_q;
	idx_t hole_start_q;
	idx_t hole_length_q;
	logic range_error_q;

	// RAM port
	logic  ram_re;
	logic  ram_we;
	word_t ram_wdata;
	word_t ram_rdata;

	bbc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.re    (ram_re),
		.we    (ram_we),
		.addr  (row_q),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// request decode
	logic [SUM_W-1:0] in_sum;
	logic             idx_oob;
	logic             sum_oob;
	logic             req_err;

	assign in_sum  = SUM_W'(block_index) + SUM_W'(block_count);
	assign idx_oob = SUM_W'(block_index) >= BLOCKS_SUM;
	assign sum_oob = in_sum > BLOCKS_SUM;
	assign req_err = ((mode == MODE_BIT) && idx_oob) ||
	                 ((mode == MODE_RELOC) && (idx_oob || sum_oob));

	// word just read; a row never written reads as all free
	word_t word;
	word_t rmask;
	word_t bit_sel;

	assign word    = rd_valid_q ? ram_rdata : '0;
	assign rmask   = range_mask(row_q, lo_q, last_q);
	assign bit_sel = word_t'(1) << bit_of(idx_q);

	// backward search for the start of the free run holding idx_q
	logic             first_row;
	logic             hit_used;
	word_t            cand;
	logic             srch_done;
	idx_t             srch_s;
	logic [SUM_W-1:0] set_sum;

	assign first_row = row_q == row_of(idx_q);
	assign hit_used  = first_row && word[bit_of(idx_q)];
	assign cand      = first_row ? (word & ~({WORD_W{1'b1}} << bit_of(idx_q))) : word;
	assign srch_done = hit_used || (cand != '0) || (row_q == '0);
	assign srch_s    = hit_used ? idx_q :
	                   (cand != '0) ? ({row_q, last_set(cand)} + idx_t'(1)) : '0;
	assign set_sum   = SUM_W'(srch_s) + SUM_W'(cnt_q) - SUM_W'(1);

	// forward hole search: a used-to-free edge, then the next used block
	word_t   fall;
	bitpos_t fall_pos;
	word_t   tail;
	logic    hole_hit;
	idx_t    hole_p;
	idx_t    hole_end;

	assign fall     = ~word & {word[WORD_W-2:0], prev_msb_q};
	assign fall_pos = first_set(fall);
	assign tail     = in_hole_q ? word : (word & ({WORD_W{1'b1}} << fall_pos));
	assign hole_hit = (in_hole_q || (fall != '0)) && (tail != '0);
	assign hole_p   = in_hole_q ? hole_p_q : {row_q, fall_pos};
	assign hole_end = {row_q, first_set(tail)};

	// RAM control
	always_comb begin
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = word;
		unique case (state_q) inside
			ST_BIT_RD, ST_CLR_RD, ST_SRCH_RD, ST_SET_RD, ST_HOLE_RD: begin
				ram_re = 1'b1;
			end
			ST_BIT_WR: begin
				ram_we    = 1'b1;
				ram_wdata = bit_val_q ? (word | bit_sel) : (word & ~bit_sel);
			end
			ST_CLR_WR: begin
				ram_we    = 1'b1;
				ram_wdata = word & ~rmask;
			end
			ST_SET_WR: begin
				ram_we    = 1'b1;
				ram_wdata = word | rmask;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// sequencer; payload registers take no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
			in_hole_q   <= 1'b0;
			prev_msb_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// capture the row's valid flop alongside the RAM read
			rd_valid_q <= row_valid_q[row_q];
			if (ram_we)
				row_valid_q[row_q] <= 1'b1;

			// load a finished result, or drop the one just taken
			if ((state_q == ST_DONE) && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q             <= block_index;
						cnt_q             <= block_count;
						bit_val_q         <= bit_value;
						res_new_start_q   <= '0;
						res_hole_found_q  <= 1'b0;
						res_hole_start_q  <= '0;
						res_hole_length_q <= '0;
						res_range_error_q <= req_err;
						row_q             <= (mode == MODE_HOLE) ? row_t'(0) :
						                     row_of(block_index);
						case (mode)
							MODE_BIT: begin
								if (idx_oob) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_BIT_RD;
								end
							end
							MODE_RELOC: begin
								if (idx_oob || sum_oob) begin
									state_q <= ST_DONE;
								end else if (block_count == '0) begin
									state_q <= ST_SRCH_RD;
								end else begin
									lo_q    <= block_index;
									last_q  <= in_sum[IDX_W-1:0] - idx_t'(1);
									state_q <= ST_CLR_RD;
								end
							end
							MODE_HOLE: begin
								in_hole_q  <= 1'b0;
								prev_msb_q <= 1'b0;
								state_q    <= ST_HOLE_RD;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_BIT_RD: begin
					state_q <= ST_BIT_WR;
				end
				ST_BIT_WR: begin
					state_q <= ST_DONE;
				end
				ST_CLR_RD: begin
					state_q <= ST_CLR_WR;
				end
				ST_CLR_WR: begin
					if (row_q == row_of(last_q)) begin
						row_q   <= row_of(idx_q);
						state_q <= ST_SRCH_RD;
					end else begin
						row_q   <= row_q + row_t'(1);
						state_q <= ST_CLR_RD;
					end
				end
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_EV;
				end
				ST_SRCH_EV: begin
					if (srch_done) begin
						res_new_start_q <= srch_s;
						if (cnt_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							lo_q    <= srch_s;
							last_q  <= set_sum[IDX_W-1:0];
							row_q   <= row_of(srch_s);
							state_q <= ST_SET_RD;
						end
					end else begin
						row_q   <= row_q - row_t'(1);
						state_q <= ST_SRCH_RD;
					end
				end
				ST_SET_RD: begin
					state_q <= ST_SET_WR;
				end
				ST_SET_WR: begin
					if (row_q == row_of(last_q)) begin
						state_q <= ST_DONE;
					end else begin
						row_q   <= row_q + row_t'(1);
						state_q <= ST_SET_RD;
					end
				end
				ST_HOLE_RD: begin
					state_q <= ST_HOLE_EV;
				end
				ST_HOLE_EV: begin
					if (hole_hit) begin
						res_hole_found_q  <= 1'b1;
						res_hole_start_q  <= hole_p;
						res_hole_length_q <= hole_end - hole_p;
						state_q           <= ST_DONE;
					end else begin
						// hold the start of an open free run across words
						if (!in_hole_q && (fall != '0)) begin
							in_hole_q <= 1'b1;
							hole_p_q  <= hole_p;
						end
						if (row_q == ROW_LAST) begin
							state_q <= ST_DONE;
						end else begin
							row_q      <= row_q + row_t'(1);
							prev_msb_q <= word[WORD_W-1];
							state_q    <= ST_HOLE_RD;
						end
					end
				end
				ST_DONE: begin
					// advance only when the output register is free or being emptied
					if (!out_valid_q || !out_stall) begin
						new_start_q   <= res_new_start_q;
						hole_found_q  <= res_hole_found_q;
						hole_start_q  <= res_hole_start_q;
						hole_length_q <= res_hole_length_q;
						range_error_q <= res_range_error_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = state_q != ST_IDLE;
	assign out_valid   = out_valid_q;
	assign new_start   = new_start_q;
	assign hole_found  = hole_found_q;
	assign hole_start  = hole_start_q;
	assign hole_length = hole_length_q;
	assign range_error = range_error_q;

	`BBC_ASSERT_NOW(a_wb_follows_read, ram_we, $past(ram_re) && ($past(row_q) == row_q))
	`BBC_ASSERT_NOW(a_set_in_range, state_q == ST_SET_WR,
		(row_q >= row_of(lo_q)) && (row_q <= row_of(last_q)))
	`BBC_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_q != ST_IDLE)
	`BBC_ASSERT_NEXT(a_done_loads, (state_q == ST_DONE) && (!out_valid_q || !out_stall),
		out_valid_q && (state_q == ST_IDLE))
	`BBC_ASSERT_NOW(a_hole_bounded, out_valid_q && hole_found_q,
		(hole_start_q != '0) && (hole_length_q != '0) && !range_error_q)

endmodule

`default_nettype wire
